@@ sv/gpma_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package gpma_pkg;

  localparam int MAX_WINDOW  = 255;
  localparam int COORD_WIDTH = 17;
  localparam int CH_COUNT    = 4;
  localparam int CFG_WIDTH   = 8;
  localparam int COUNT_WIDTH = $clog2(MAX_WINDOW + 1);
  localparam int SLOT_WIDTH  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_WIDTH   = COORD_WIDTH + COUNT_WIDTH;
  localparam int MAG_WIDTH   = SUM_WIDTH - 1;
  localparam int STEP_WIDTH  = $clog2(MAG_WIDTH + 1);
  localparam int FIFO_DEPTH  = 2;
  localparam int FPTR_WIDTH  = $clog2(FIFO_DEPTH);
  localparam int FCNT_WIDTH  = $clog2(FIFO_DEPTH + 1);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [SUM_WIDTH-1:0]   sum_t;
  typedef logic [COUNT_WIDTH-1:0]        count_t;
  typedef logic [SLOT_WIDTH-1:0]         slot_t;
  typedef logic [CFG_WIDTH-1:0]          cfg_data_t;

  // One accepted frame, classified by the front end.
  typedef struct packed {
    coord_t [CH_COUNT-1:0] coords;
    slot_t                 slot;
    logic                  evict;
    count_t                count;
  } entry_t;

endpackage
`default_nettype wire

@@ sv/gpma_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface gpma_sample_if;
  logic            valid;
  logic            ready;
  gpma_pkg::coord_t pupil_x;
  gpma_pkg::coord_t pupil_y;
  gpma_pkg::coord_t glint_x;
  gpma_pkg::coord_t glint_y;
  modport source (output valid, pupil_x, pupil_y, glint_x, glint_y, input ready);
  modport sink (input valid, pupil_x, pupil_y, glint_x, glint_y, output ready);
endinterface

interface gpma_avg_if;
  logic            valid;
  logic            ready;
  gpma_pkg::coord_t avg_pupil_x;
  gpma_pkg::coord_t avg_pupil_y;
  gpma_pkg::coord_t avg_glint_x;
  gpma_pkg::coord_t avg_glint_y;
  modport source (output valid, avg_pupil_x, avg_pupil_y, avg_glint_x, avg_glint_y,
                  input ready);
  modport sink (input valid, avg_pupil_x, avg_pupil_y, avg_glint_x, avg_glint_y,
                output ready);
endinterface

interface gpma_cfg_if;
  logic                valid;
  logic                ready;
  gpma_pkg::cfg_data_t window_size;
  modport source (output valid, window_size, input ready);
  modport sink (input valid, window_size, output ready);
endinterface
`default_nettype wire

@@ sv/gpma_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gpma_front (
  input  wire logic              clk,
  input  wire logic              rst,
  gpma_cfg_if.sink               cfg,
  gpma_sample_if.sink            samples,
  output gpma_pkg::entry_t       push_data,
  output logic                   push,
  input  wire logic              full,
  output logic                   clear
);

  gpma_pkg::count_t window_size, window_size_next;
  gpma_pkg::count_t fill_count, fill_count_next;
  gpma_pkg::count_t write_slot, write_slot_next;
  gpma_pkg::count_t slot_cur, slot_inc;
  logic             evict;
  logic             accept;

  assign cfg.ready     = 1'b1;
  assign clear         = cfg.valid && cfg.ready;
  assign samples.ready = !full;
  assign accept        = samples.valid && samples.ready;
  assign push          = accept;

  always_comb begin
    slot_cur = (write_slot >= window_size) ? '0 : write_slot;
    slot_inc = slot_cur + gpma_pkg::count_t'(1);
    evict    = (fill_count >= window_size);

    // zero is held as one, anything past the ring depth saturates
    if (cfg.window_size == '0) begin
      window_size_next = gpma_pkg::count_t'(1);
    end else if (32'(cfg.window_size) > gpma_pkg::MAX_WINDOW) begin
      window_size_next = gpma_pkg::count_t'(gpma_pkg::MAX_WINDOW);
    end else begin
      window_size_next = gpma_pkg::count_t'(cfg.window_size);
    end

    fill_count_next = evict ? fill_count : fill_count + gpma_pkg::count_t'(1);
    write_slot_next = (slot_inc >= window_size) ? '0 : slot_inc;

    push_data.coords[0] = samples.pupil_x;
    push_data.coords[1] = samples.pupil_y;
    push_data.coords[2] = samples.glint_x;
    push_data.coords[3] = samples.glint_y;
    push_data.slot      = slot_cur[gpma_pkg::SLOT_WIDTH-1:0];
    push_data.evict     = evict;
    push_data.count     = fill_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= gpma_pkg::count_t'(1);
      fill_count  <= '0;
      write_slot  <= '0;
    end else if (clear) begin
      window_size <= window_size_next;
      fill_count  <= '0;
      write_slot  <= '0;
    end else if (accept) begin
      fill_count <= fill_count_next;
      write_slot <= write_slot_next;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= window_size)
    else $error("fill count past window size");
  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    write_slot < window_size)
    else $error("write slot outside window");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    clear |=> (fill_count == '0) && (write_slot == '0))
    else $error("window not cleared after config write");
`endif

endmodule
`default_nettype wire

@@ sv/gpma_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gpma_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  gpma_pkg::entry_t       push_data,
  output logic                   full,
  input  wire logic              pop,
  output logic                   head_valid,
  output gpma_pkg::entry_t       head
);

  gpma_pkg::entry_t                mem [gpma_pkg::FIFO_DEPTH];
  logic [gpma_pkg::FPTR_WIDTH-1:0] wr_ptr, rd_ptr;
  logic [gpma_pkg::FCNT_WIDTH-1:0] count;
  logic                            do_push, do_pop;

  assign full       = (count == gpma_pkg::FCNT_WIDTH'(gpma_pkg::FIFO_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (32'(wr_ptr) == gpma_pkg::FIFO_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (32'(rd_ptr) == gpma_pkg::FIFO_DEPTH - 1) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/gpma_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gpma_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  gpma_pkg::sum_t [gpma_pkg::CH_COUNT-1:0] dividend,
  input  gpma_pkg::count_t                       divisor,
  output logic                                   done,
  output gpma_pkg::coord_t [gpma_pkg::CH_COUNT-1:0] quotient
);

  localparam int MW = gpma_pkg::MAG_WIDTH;
  localparam int CW = gpma_pkg::COUNT_WIDTH;

  logic [MW-1:0]                  mag      [gpma_pkg::CH_COUNT];
  logic [CW-1:0]                  rem      [gpma_pkg::CH_COUNT];
  logic                           neg      [gpma_pkg::CH_COUNT];
  logic [MW-1:0]                  mag_next [gpma_pkg::CH_COUNT];
  logic [CW-1:0]                  rem_next [gpma_pkg::CH_COUNT];
  logic [gpma_pkg::STEP_WIDTH-1:0] step;
  gpma_pkg::count_t               dvsr;
  logic                           busy;

  // one restoring step per lane; the four lanes share the step counter
  always_comb begin
    logic [CW:0] partial;
    logic [MW-1:0] qmag;
    for (int c = 0; c < gpma_pkg::CH_COUNT; c++) begin
      partial = {rem[c], mag[c][MW-1]};
      if (partial >= {1'b0, dvsr}) begin
        rem_next[c] = CW'(partial - {1'b0, dvsr});
        mag_next[c] = {mag[c][MW-2:0], 1'b1};
      end else begin
        rem_next[c] = partial[CW-1:0];
        mag_next[c] = {mag[c][MW-2:0], 1'b0};
      end
      qmag        = neg[c] ? (~mag[c] + 1'b1) : mag[c];
      quotient[c] = qmag[gpma_pkg::COORD_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    gpma_pkg::sum_t abs_v;
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (32'(step) == MW - 1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
    if (start) begin
      dvsr <= divisor;
      for (int c = 0; c < gpma_pkg::CH_COUNT; c++) begin
        abs_v  = dividend[c][gpma_pkg::SUM_WIDTH-1] ? -dividend[c] : dividend[c];
        neg[c] <= dividend[c][gpma_pkg::SUM_WIDTH-1];
        mag[c] <= abs_v[MW-1:0];
        rem[c] <= '0;
      end
    end else if (busy) begin
      for (int c = 0; c < gpma_pkg::CH_COUNT; c++) begin
        mag[c] <= mag_next[c];
        rem[c] <= rem_next[c];
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/gpma_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module gpma_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              clear,
  input  wire logic              head_valid,
  input  gpma_pkg::entry_t       head,
  output logic                   pop,
  gpma_avg_if.source             averages
);

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_START, S_DIVIDE, S_PUBLISH} state_t;

  state_t                                     state;
  gpma_pkg::entry_t                           cur;
  gpma_pkg::sum_t [gpma_pkg::CH_COUNT-1:0]    sums, sums_next;
  gpma_pkg::coord_t [gpma_pkg::CH_COUNT-1:0]  ring [gpma_pkg::MAX_WINDOW];
  gpma_pkg::coord_t [gpma_pkg::CH_COUNT-1:0]  ring_q;
  gpma_pkg::coord_t [gpma_pkg::CH_COUNT-1:0]  quotient;
  logic                                       div_start, div_done;
  logic                                       ring_wr;
  logic                                       publish;

  assign pop       = (state == S_IDLE) && head_valid;
  assign ring_wr   = (state == S_LOAD);
  assign div_start = (state == S_START);
  // output register frees up on the same edge it is taken
  assign publish   = (state == S_PUBLISH) && (!averages.valid || averages.ready);

  always_ff @(posedge clk) begin
    if (pop) begin
      ring_q <= ring[head.slot];
    end
    if (ring_wr) begin
      ring[cur.slot] <= cur.coords;
    end
  end

  always_comb begin
    for (int c = 0; c < gpma_pkg::CH_COUNT; c++) begin
      sums_next[c] = sums[c] + gpma_pkg::sum_t'(cur.coords[c])
                   - (cur.evict ? gpma_pkg::sum_t'(ring_q[c]) : gpma_pkg::sum_t'(0));
    end
  end

  gpma_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sums),
    .divisor  (cur.count),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      sums           <= '0;
      averages.valid <= 1'b0;
    end else begin
      if (publish) begin
        averages.valid <= 1'b1;
      end else if (averages.ready) begin
        averages.valid <= 1'b0;
      end
      if (clear) begin
        sums <= '0;
      end else if (state == S_LOAD) begin
        sums <= sums_next;
      end
      unique case (state)
        S_IDLE: begin
          if (head_valid) begin
            cur   <= head;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          state <= S_START;
        end
        S_START: begin
          state <= S_DIVIDE;
        end
        S_DIVIDE: begin
          if (div_done) begin
            state <= S_PUBLISH;
          end
        end
        S_PUBLISH: begin
          if (publish) begin
            averages.avg_pupil_x <= quotient[0];
            averages.avg_pupil_y <= quotient[1];
            averages.avg_glint_x <= quotient[2];
            averages.avg_glint_y <= quotient[3];
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sv/gaze_point_moving_average.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Sliding-window average of one pupil point and one glint point (signed Q12.4).
// A front end takes each frame, tracks the fill count and ring slot, and queues
// it in a two-entry FIFO; the back end reads the ring memory, updates the four
// running sums and divides them by the number of frames held with four
// bit-serial lanes of a shared restoring divider (truncation toward zero).
// The back end steps each frame through load, start, divide (24 divider steps)
// and publish; the front keeps accepting while the FIFO has room, and a finished result
// waits in the output register while the next frame is loaded and divided.
// Writing window_size (0 is held as 1) clears the window; write it only while
// the block is idle.
module gaze_point_moving_average (
  input  wire logic    clk,
  input  wire logic    rst,
  gpma_cfg_if.sink     cfg,
  gpma_sample_if.sink  samples,
  gpma_avg_if.source   averages
);

  gpma_pkg::entry_t push_data, head;
  logic             push, full, pop, head_valid, clear;

  gpma_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .samples   (samples),
    .push_data (push_data),
    .push      (push),
    .full      (full),
    .clear     (clear)
  );

  gpma_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  gpma_back u_back (
    .clk        (clk),
    .rst        (rst),
    .clear      (clear),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .averages   (averages)
  );

endmodule
`default_nettype wire

@@ verif/gaze_point_moving_average_test.sv @@
`timescale 1ns / 1ps

typedef struct packed {
  gpma_pkg::coord_t pupil_x;
  gpma_pkg::coord_t pupil_y;
  gpma_pkg::coord_t glint_x;
  gpma_pkg::coord_t glint_y;
} point_set_t;

class window_avg_scoreboard;
  gpma_pkg::coord_t ring [gpma_pkg::CH_COUNT][gpma_pkg::MAX_WINDOW];
  longint     sums [gpma_pkg::CH_COUNT];
  int unsigned fill_count;
  int unsigned write_slot;
  int unsigned window_len;
  point_set_t avg_q [$];
  int         errors;

  function new();
    window_len = 1;
    errors = 0;
    clear_window();
  endfunction

  function void clear_window();
    for (int c = 0; c < gpma_pkg::CH_COUNT; c++) sums[c] = 0;
    fill_count = 0;
    write_slot = 0;
  endfunction

  function void set_window(gpma_pkg::cfg_data_t v);
    window_len = (v == 0) ? 1 : ((v > gpma_pkg::MAX_WINDOW) ? gpma_pkg::MAX_WINDOW : v);
    clear_window();
  endfunction

  function int pending();
    return avg_q.size();
  endfunction

  // Accepted frame: update the window and queue its average.
  function void note_frame(point_set_t f);
    gpma_pkg::coord_t x [gpma_pkg::CH_COUNT];
    gpma_pkg::coord_t avg [gpma_pkg::CH_COUNT];
    int unsigned slot;
    point_set_t  exp_avg;
    x[0] = f.pupil_x;
    x[1] = f.pupil_y;
    x[2] = f.glint_x;
    x[3] = f.glint_y;
    slot = (write_slot >= window_len) ? 0 : write_slot;
    for (int c = 0; c < gpma_pkg::CH_COUNT; c++) begin
      if (fill_count >= window_len) sums[c] -= longint'(ring[c][slot]);
      ring[c][slot] = x[c];
      sums[c] += longint'(x[c]);
    end
    if (fill_count < window_len) fill_count++;
    // signed division truncates toward zero
    for (int c = 0; c < gpma_pkg::CH_COUNT; c++)
      avg[c] = gpma_pkg::coord_t'(sums[c] / longint'(fill_count));
    slot++;
    write_slot = (slot >= window_len) ? 0 : slot;
    exp_avg.pupil_x = avg[0];
    exp_avg.pupil_y = avg[1];
    exp_avg.glint_x = avg[2];
    exp_avg.glint_y = avg[3];
    avg_q.insert(avg_q.size(), exp_avg);
  endfunction

  function void check_average(point_set_t got);
    point_set_t want;
    if (avg_q.size() == 0) begin
      $error("average with no request outstanding: %0d %0d %0d %0d",
             got.pupil_x, got.pupil_y, got.glint_x, got.glint_y);
      errors++;
      return;
    end
    want = avg_q.pop_front();
    if (got.pupil_x !== want.pupil_x) begin
      $error("avg_pupil_x: expected %0d, got %0d", want.pupil_x, got.pupil_x);
      errors++;
    end
    if (got.pupil_y !== want.pupil_y) begin
      $error("avg_pupil_y: expected %0d, got %0d", want.pupil_y, got.pupil_y);
      errors++;
    end
    if (got.glint_x !== want.glint_x) begin
      $error("avg_glint_x: expected %0d, got %0d", want.glint_x, got.glint_x);
      errors++;
    end
    if (got.glint_y !== want.glint_y) begin
      $error("avg_glint_y: expected %0d, got %0d", want.glint_y, got.glint_y);
      errors++;
    end
  endfunction
endclass

module gaze_point_moving_average_test;

  logic clk;
  logic rst;
  bit   quiet_tail;

  gpma_cfg_if    cfg_ch ();
  gpma_sample_if sample_ch ();
  gpma_avg_if    avg_ch ();

  window_avg_scoreboard sb;

  gaze_point_moving_average DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_ch),
    .samples  (sample_ch),
    .averages (avg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("gaze_point_moving_average_test: done, errors");
    $finish;
  end

  // Receiver: ready with random stall bursts.
  initial begin
    int stall_left;
    stall_left = 0;
    avg_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        avg_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        avg_ch.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        avg_ch.ready <= 1'b0;
      end else begin
        avg_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    point_set_t got;
    if (!rst && avg_ch.valid && avg_ch.ready) begin
      got.pupil_x = avg_ch.avg_pupil_x;
      got.pupil_y = avg_ch.avg_pupil_y;
      got.glint_x = avg_ch.avg_glint_x;
      got.glint_y = avg_ch.avg_glint_y;
      sb.check_average(got);
    end
  end

  function automatic gpma_pkg::coord_t random_coord();
    gpma_pkg::coord_t corners [4] = '{gpma_pkg::coord_t'(-65536), gpma_pkg::coord_t'(65535),
                                      gpma_pkg::coord_t'(0), gpma_pkg::coord_t'(-1)};
    if ($urandom_range(0, 7) == 0) return corners[$urandom_range(0, 3)];
    return gpma_pkg::coord_t'($urandom);
  endfunction

  task automatic send_point(gpma_pkg::coord_t px, gpma_pkg::coord_t py,
                            gpma_pkg::coord_t gx, gpma_pkg::coord_t gy);
    point_set_t f;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    f.pupil_x = px;
    f.pupil_y = py;
    f.glint_x = gx;
    f.glint_y = gy;
    sample_ch.valid   <= 1'b1;
    sample_ch.pupil_x <= px;
    sample_ch.pupil_y <= py;
    sample_ch.glint_x <= gx;
    sample_ch.glint_y <= gy;
    do @(posedge clk); while (!sample_ch.ready);
    sb.note_frame(f);
  endtask

  task automatic send_random(int n);
    for (int i = 0; i < n; i++)
      send_point(random_coord(), random_coord(), random_coord(), random_coord());
  endtask

  task automatic drain();
    sample_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_window(gpma_pkg::cfg_data_t v);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.window_size <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.set_window(v);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    gpma_pkg::coord_t ext [4];
    sb = new();
    ext[0] = gpma_pkg::coord_t'(-65536);
    ext[1] = gpma_pkg::coord_t'(65535);
    ext[2] = gpma_pkg::coord_t'(0);
    ext[3] = gpma_pkg::coord_t'(-1);
    quiet_tail = 1'b0;
    rst <= 1'b1;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.window_size <= '0;
    sample_ch.valid    <= 1'b0;
    sample_ch.pupil_x  <= '0;
    sample_ch.pupil_y  <= '0;
    sample_ch.glint_x  <= '0;
    sample_ch.glint_y  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset window of one
    send_point(ext[0], ext[1], ext[2], ext[3]);
    send_point(ext[1], ext[0], ext[3], ext[2]);
    send_point(ext[2], ext[3], ext[0], ext[1]);
    send_point(ext[3], ext[2], ext[1], ext[0]);
    drain();

    // zero is held as a window of one
    write_window(8'd0);
    send_point(ext[1], ext[1], ext[0], ext[0]);
    send_point(ext[0], ext[0], ext[1], ext[1]);
    send_point(ext[3], ext[3], ext[3], ext[3]);
    drain();

    // widest window: large sums of both signs, warm-up averages
    write_window(8'd255);
    for (int i = 0; i < 5; i++) send_point(ext[1], ext[1], ext[1], ext[1]);
    for (int i = 0; i < 5; i++) send_point(ext[0], ext[0], ext[0], ext[0]);
    send_point(ext[3], ext[0], ext[1], ext[3]);
    drain();

    // small window with eviction and odd/negative rounding
    write_window(8'd2);
    send_point(ext[3], ext[1], ext[0], ext[2]);
    send_point(ext[2], ext[0], ext[1], ext[3]);
    send_point(ext[0], ext[3], ext[3], ext[1]);
    send_point(ext[1], ext[2], ext[2], ext[0]);
    drain();

    write_window(8'd3);
    send_random(40);
    drain();

    write_window(8'd1);
    send_random(20);
    for (int p = 0; p < 4; p++) begin
      drain();
      write_window(gpma_pkg::cfg_data_t'($urandom_range(1, 20)));
      send_random(10);
      // on the second pass the sender holds off until the block has drained
      if (p == 1) drain();
      send_random(10);
    end
    drain();

    // full window wraps the ring; idle-free at the tail
    write_window(8'd255);
    send_random(230);
    quiet_tail = 1'b1;
    send_random(40);
    drain();

    repeat (64) @(posedge clk);
    if (sb.errors == 0) begin
      $display("gaze_point_moving_average_test: done, clean");
    end else begin
      $display("gaze_point_moving_average_test: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/gpma_pkg.sv
sv/gpma_ifs.sv
sv/gpma_front.sv
sv/gpma_fifo.sv
sv/gpma_div.sv
sv/gpma_back.sv
sv/gaze_point_moving_average.sv
verif/gaze_point_moving_average_test.sv
